### src/pfm_pkg.sv
// Package for the period frequency meter: shared constants and state types.
// Used by every module of the block; depends on nothing.
package pfm_pkg;

	// Default width of the period tick counter.
	localparam int unsigned COUNT_WIDTH_DEF = 16;

	// Width of the ticks-per-second register and of the quotient.
	localparam int unsigned TPS_WIDTH = 16;

	// Reset value of the ticks-per-second register.
	localparam logic [TPS_WIDTH-1:0] TPS_RESET = 16'd10000;

	// Digit code shown on both digits when the frequency is out of range.
	localparam logic [3:0] OVER_CODE = 4'd14;

	// First frequency that no longer fits in two digits.
	localparam logic [TPS_WIDTH-1:0] FREQ_LIMIT = 16'd100;

	// Number of entries in the queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Phase of the measurement in the front part.
	typedef enum logic [1:0] {
		PH_WAIT_END,
		PH_WAIT_RISE,
		PH_HIGH,
		PH_LOW
	} phase_t;

	// State of the divider in the back part.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

	// Outputs of the front state machine for one tick.
	typedef struct packed {
		logic load_one;
		logic count_up;
		logic finish;
	} front_ctl_t;

endpackage

### src/period_frequency_meter_bcd.sv
// Period frequency meter with two-digit decimal output. Every request on the
// input side is one sample tick with the signal level; the front takes one tick
// per clock while the queue has room and counts the ticks of every other signal
// period, from a rising edge to the next. The back part loads each finished
// period, runs the serial restoring division of ticks_per_second by the count
// (one quotient bit per clock), splits the digits and registers the result.
// A two-entry queue sits between the two parts, so full only rises if periods
// end faster than the back part takes them or finished results are left
// waiting on the output. The result is the frequency in hertz, its tens and
// units digits, and an over-range flag with both digits showing 14 at 100 Hz
// or more. The user writes ticks_per_second through the cfg port while idle;
// not enforced by the block. Uses pfm_pkg, pfm_front, pfm_queue and pfm_back.
module period_frequency_meter_bcd
	import pfm_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 signal_level,
	output logic                 empty,
	input  logic                 pop,
	output logic [3:0]           tens_digit,
	output logic [3:0]           units_digit,
	output logic                 over_range,
	output logic [TPS_WIDTH-1:0] frequency_hz,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [TPS_WIDTH-1:0] cfg_data
);

	localparam int unsigned JOB_W = TPS_WIDTH + COUNT_WIDTH;

	logic                   job_push;
	logic                   job_full;
	logic [TPS_WIDTH-1:0]   front_tps;
	logic [COUNT_WIDTH-1:0] front_count;
	logic                   job_pop;
	logic                   job_empty;
	logic [JOB_W-1:0]       job_data;

	// Front: phase tracking and period counting.
	pfm_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.signal_level(signal_level),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.job_push    (job_push),
		.job_full    (job_full),
		.job_tps     (front_tps),
		.job_count   (front_count)
	);

	// Queue of finished periods.
	pfm_queue #(
		.DATA_WIDTH(JOB_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_data({front_tps, front_count}),
		.q_full (job_full),
		.rd_en  (job_pop),
		.rd_data(job_data),
		.q_empty(job_empty)
	);

	// Back: division and digit output.
	pfm_back #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_empty   (job_empty),
		.job_pop     (job_pop),
		.job_tps     (job_data[JOB_W-1:COUNT_WIDTH]),
		.job_count   (job_data[COUNT_WIDTH-1:0]),
		.empty       (empty),
		.pop         (pop),
		.tens_digit  (tens_digit),
		.units_digit (units_digit),
		.over_range  (over_range),
		.frequency_hz(frequency_hz)
	);

endmodule

### src/pfm_front.sv
// Front part of the period frequency meter: phase tracking, period counter,
// configuration register and hand-off of finished periods. Uses pfm_pkg.
module pfm_front
	import pfm_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic                   signal_level,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [TPS_WIDTH-1:0]   cfg_data,
	output logic                   job_push,
	input  logic                   job_full,
	output logic [TPS_WIDTH-1:0]   job_tps,
	output logic [COUNT_WIDTH-1:0] job_count
);

	phase_t                 phase_q;
	phase_t                 phase_d;
	front_ctl_t             ctl;
	logic [COUNT_WIDTH-1:0] period_count_q;
	logic [TPS_WIDTH-1:0]   tps_q;
	logic                   accept;

	// A request is taken whenever the queue to the back part has room.
	assign full      = job_full;
	assign accept    = push && !job_full;
	assign cfg_ready = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_valid) begin
			tps_q <= cfg_data;
		end
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_WAIT_END: begin
				if (!signal_level) phase_d = PH_WAIT_RISE;
			end
			PH_WAIT_RISE: begin
				if (signal_level) phase_d = PH_HIGH;
			end
			PH_HIGH: begin
				if (!signal_level) phase_d = PH_LOW;
			end
			PH_LOW: begin
				if (signal_level) phase_d = PH_WAIT_END;
			end
			default: phase_d = PH_WAIT_END;
		endcase
	end

	// Counter controls for the current phase.
	always_comb begin
		ctl = '0;
		unique case (phase_q)
			PH_WAIT_END: ctl = '0;
			PH_WAIT_RISE: begin
				ctl.load_one = signal_level;
			end
			PH_HIGH: begin
				ctl.count_up = 1'b1;
			end
			PH_LOW: begin
				ctl.count_up = !signal_level;
				ctl.finish   = signal_level;
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_END;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	// Period counter, saturating at its maximum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_count_q <= '0;
		end else if (accept) begin
			if (ctl.load_one) begin
				period_count_q <= COUNT_WIDTH'(1);
			end else if (ctl.finish) begin
				period_count_q <= '0;
			end else if (ctl.count_up && (period_count_q != '1)) begin
				period_count_q <= period_count_q + COUNT_WIDTH'(1);
			end
		end
	end

	// A rising edge in the low phase closes the period and hands it on.
	assign job_push  = accept && ctl.finish;
	assign job_tps   = tps_q;
	assign job_count = period_count_q;

endmodule

### src/pfm_queue.sv
// Short first-in first-out queue of finished periods between front and back.
// Uses pfm_pkg for its depth.
module pfm_queue
	import pfm_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = TPS_WIDTH + COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [DATA_WIDTH-1:0] wr_data,
	output logic                  q_full,
	input  logic                  rd_en,
	output logic [DATA_WIDTH-1:0] rd_data,
	output logic                  q_empty
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      fill_q;
	logic                  do_wr;
	logic                  do_rd;

	assign q_full  = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign q_empty = (fill_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = entry_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
				                                                 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
				                                                 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

### src/pfm_back.sv
// Back part of the period frequency meter: serial restoring divider, digit
// split and the result register. Uses pfm_pkg.
module pfm_back
	import pfm_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_empty,
	output logic                   job_pop,
	input  logic [TPS_WIDTH-1:0]   job_tps,
	input  logic [COUNT_WIDTH-1:0] job_count,
	output logic                   empty,
	input  logic                   pop,
	output logic [3:0]             tens_digit,
	output logic [3:0]             units_digit,
	output logic                   over_range,
	output logic [TPS_WIDTH-1:0]   frequency_hz
);

	localparam int unsigned STEP_W = $clog2(TPS_WIDTH);

	back_state_t            state_q;
	back_state_t            state_d;
	logic [TPS_WIDTH-1:0]   quo_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [COUNT_WIDTH-1:0] den_q;
	logic [STEP_W-1:0]      step_q;
	logic [COUNT_WIDTH:0]   trial;
	logic                   ge;
	logic [COUNT_WIDTH:0]   diff;
	logic                   out_valid_q;
	logic                   out_free;
	logic                   is_over;
	logic [6:0]             low_freq;
	logic [14:0]            tens_prod;
	logic [3:0]             tens_val;
	logic [6:0]             tens_x10;
	logic [3:0]             units_val;
	logic                   load;
	logic                   finish;

	assign out_free = !out_valid_q || pop;

	// One quotient bit per step: shift in the next numerator bit and subtract.
	assign trial = {rem_q, quo_q[TPS_WIDTH-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	// Next state of the divider.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!job_empty) state_d = BK_DIV;
			end
			BK_DIV: begin
				if (step_q == STEP_W'(TPS_WIDTH - 1)) state_d = BK_DONE;
			end
			BK_DONE: begin
				if (out_free) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Controls of the divider.
	always_comb begin
		load   = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			BK_IDLE: load = !job_empty;
			BK_DIV:  load = 1'b0;
			BK_DONE: finish = out_free;
			default: load = 1'b0;
		endcase
	end

	assign job_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Divider datapath: the numerator register fills with quotient bits.
	always_ff @(posedge clk) begin
		if (load) begin
			quo_q  <= job_tps;
			den_q  <= job_count;
			rem_q  <= '0;
			step_q <= '0;
		end else if (state_q == BK_DIV) begin
			quo_q  <= {quo_q[TPS_WIDTH-2:0], ge};
			rem_q  <= ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
			step_q <= step_q + STEP_W'(1);
		end
	end

	// Digit split for frequencies below 100: multiply by 205/2048 for tens.
	assign is_over   = (quo_q >= FREQ_LIMIT);
	assign low_freq  = quo_q[6:0];
	assign tens_prod = 15'(low_freq) * 15'd205;
	assign tens_val  = tens_prod[14:11];
	assign tens_x10  = 7'(tens_val) * 7'd10;
	assign units_val = 4'(low_freq - tens_x10);

	// Result register, free again once the waiting result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			frequency_hz <= quo_q;
			over_range   <= is_over;
			tens_digit   <= is_over ? OVER_CODE : tens_val;
			units_digit  <= is_over ? OVER_CODE : units_val;
		end
	end

	assign empty = !out_valid_q;

endmodule

### src/pfm_checker.sv
// Port-level checker for the period frequency meter and its bind statement.
// Uses pfm_pkg; attaches to period_frequency_meter_bcd.
module pfm_checker
	import pfm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 empty,
	input logic                 pop,
	input logic [3:0]           tens_digit,
	input logic [3:0]           units_digit,
	input logic                 over_range,
	input logic [TPS_WIDTH-1:0] frequency_hz
);

	// An over-range result shows the over-range code and a large frequency.
	a_over_code: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && over_range) |->
			(tens_digit == OVER_CODE) && (units_digit == OVER_CODE)
			&& (frequency_hz >= FREQ_LIMIT))
		else $error("over-range result with wrong digits or frequency");

	// An in-range result has digits that spell out the frequency.
	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !over_range) |->
			(frequency_hz < FREQ_LIMIT) && (units_digit < 4'd10)
			&& ((16'(tens_digit) * 16'd10 + 16'(units_digit)) == frequency_hz))
		else $error("digits do not match the frequency");

	// A result that is not taken stays unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty && $stable(frequency_hz) && $stable(over_range))
		else $error("waiting result changed before it was taken");

endmodule

bind period_frequency_meter_bcd pfm_checker u_pfm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.tens_digit  (tens_digit),
	.units_digit (units_digit),
	.over_range  (over_range),
	.frequency_hz(frequency_hz)
);

### bench/period_frequency_meter_bcd_tb.sv
// Testbench for period_frequency_meter_bcd: sample ticks go in, measured readings come out.
// Needs pfm_pkg and the period_frequency_meter_bcd RTL. It carries its own model of the meter.
`timescale 1ns / 100ps

module period_frequency_meter_bcd_tb;
	import pfm_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 48;
	localparam int MAX_WAIT     = 17;
	localparam int RANDOM_ITEMS = 1050;
	localparam int REPORT_LIMIT = 10;

	// One reading of the meter, in port order.
	typedef struct packed {
		logic [3:0]           tens;
		logic [3:0]           units;
		logic                 over;
		logic [TPS_WIDTH-1:0] freq;
	} reading_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic                 signal_level = 1'b0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [3:0]           tens_digit;
	logic [3:0]           units_digit;
	logic                 over_range;
	logic [TPS_WIDTH-1:0] frequency_hz;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [TPS_WIDTH-1:0] cfg_data = '0;

	// Sample levels waiting to be sent, and readings waiting to arrive.
	logic     level_q[$];
	reading_t reading_q[$];

	// Model of the meter.
	phase_t                     meter_phase = PH_WAIT_END;
	logic [COUNT_WIDTH_DEF-1:0] period_ticks = '0;
	logic [TPS_WIDTH-1:0]       tick_rate = TPS_RESET;

	// Idling controls, changed only away from the rising edge.
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;
	bit receiver_hold = 1'b0;

	int send_gap = 0;
	int recv_gap = 0;
	int next_gap;
	int fail_count = 0;
	int readings_seen = 0;
	int random_items = 0;
	int cycle_count = 0;

	period_frequency_meter_bcd uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.signal_level (signal_level),
		.empty        (empty),
		.pop          (pop),
		.tens_digit   (tens_digit),
		.units_digit  (units_digit),
		.over_range   (over_range),
		.frequency_hz (frequency_hz),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Advances the model by one sample tick and records any reading it yields.
	task automatic measure_tick(input logic level);
		reading_t             rd;
		logic [TPS_WIDTH-1:0] freq;
		case (meter_phase)
			PH_WAIT_END: begin
				if (!level)
					meter_phase = PH_WAIT_RISE;
			end
			PH_WAIT_RISE: begin
				if (level) begin
					period_ticks = COUNT_WIDTH_DEF'(1);
					meter_phase = PH_HIGH;
				end
			end
			PH_HIGH: begin
				if (period_ticks != '1)
					period_ticks++;
				if (!level)
					meter_phase = PH_LOW;
			end
			PH_LOW: begin
				if (!level) begin
					if (period_ticks != '1)
						period_ticks++;
				end else begin
					// Rising edge closes the period; the edge tick itself is not counted.
					if (period_ticks == 0)
						freq = '1;
					else
						freq = TPS_WIDTH'(tick_rate / period_ticks);
					rd.freq = freq;
					if (freq >= FREQ_LIMIT) begin
						rd.tens = OVER_CODE;
						rd.units = OVER_CODE;
						rd.over = 1'b1;
					end else begin
						rd.tens = 4'(freq / 10);
						rd.units = 4'(freq % 10);
						rd.over = 1'b0;
					end
					reading_q.push_back(rd);
					meter_phase = PH_WAIT_END;
					period_ticks = '0;
				end
			end
		endcase
	endtask

	// Sender: offers one sample per request, with a random wait after each one while sender_idles is set.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			signal_level <= 1'b0;
			send_gap <= 0;
		end else if (push && full) begin
			// Request stalled; hold it as it is.
		end else begin
			if (push) begin
				measure_tick(signal_level);
				next_gap = sender_idles ? $urandom_range(0, MAX_WAIT) : 0;
			end else begin
				next_gap = send_gap;
			end
			if (next_gap > 0) begin
				push <= 1'b0;
				send_gap <= next_gap - 1;
			end else if (level_q.size() != 0) begin
				push <= 1'b1;
				signal_level <= level_q.pop_front();
				send_gap <= 0;
			end else begin
				push <= 1'b0;
				send_gap <= 0;
			end
		end
	end

	// Receiver: takes readings, compares each with the oldest one predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (pop && !empty) begin
				readings_seen++;
				if (reading_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("unexpected reading: tens %0d units %0d over %0d freq %0d",
							tens_digit, units_digit, over_range, frequency_hz);
				end else begin
					reading_t want;
					want = reading_q.pop_front();
					if (want.tens !== tens_digit || want.units !== units_digit ||
							want.over !== over_range || want.freq !== frequency_hz) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display({"reading mismatch: expected tens %0d units %0d over %0d",
								" freq %0d, got tens %0d units %0d over %0d freq %0d"},
								want.tens, want.units, want.over, want.freq,
								tens_digit, units_digit, over_range, frequency_hz);
					end
				end
				recv_gap <= receiver_idles ? $urandom_range(0, MAX_WAIT) : 0;
				pop <= 1'b0;
			end else if (receiver_hold) begin
				pop <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[period_frequency_meter_bcd] ERROR");
			$finish;
		end
	end

	// Queues a run of levels written as a string of ones and zeros.
	task automatic queue_levels(input string pattern);
		for (int i = 0; i < pattern.len(); i++)
			level_q.push_back(pattern.getc(i) == "1");
	endtask

	// Waits until every sample is in and every reading out, then lets the divider settle.
	task automatic wait_idle();
		while (level_q.size() != 0 || push || reading_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes ticks_per_second once the meter is idle.
	task automatic write_tick_rate(input logic [TPS_WIDTH-1:0] value);
		wait_idle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		tick_rate = value;
		@(negedge clk);
	endtask

	// Random block: mostly clean high and low runs, some short runs of random levels as noise.
	task automatic queue_random_block(input int n_items);
		int added;
		int high_len;
		int low_len;
		added = 0;
		while (added < n_items) begin
			if ($urandom_range(0, 9) < 8) begin
				high_len = $urandom_range(1, 16);
				low_len = $urandom_range(1, 16);
				if ($urandom_range(0, 15) == 0) begin
					high_len = $urandom_range(1, 150);
					low_len = $urandom_range(1, 150);
				end
				repeat (high_len) level_q.push_back(1'b1);
				repeat (low_len) level_q.push_back(1'b0);
				added += high_len + low_len;
			end else begin
				high_len = $urandom_range(1, 8);
				repeat (high_len) level_q.push_back(1'($urandom_range(0, 1)));
				added += high_len;
			end
		end
		random_items += added;
	endtask

	initial begin
		logic [TPS_WIDTH-1:0] rate;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Shortest period at the reset rate; the opening high level is skipped.
		queue_levels("110101");
		// Either side of the two-digit limit.
		write_tick_rate(16'd199);
		queue_levels("0101");
		write_tick_rate(16'd200);
		queue_levels("0101");
		// Zero and full-scale rates, and the smallest one.
		write_tick_rate('0);
		queue_levels("0110001");
		write_tick_rate('1);
		queue_levels("0101");
		write_tick_rate(16'd1);
		queue_levels("0101");

		// Back-to-back short periods while the receiver holds off, so the meter fills up.
		write_tick_rate(TPS_RESET);
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		receiver_hold = 1'b1;
		repeat (60) queue_levels("0101");
		repeat (1500) @(negedge clk);
		receiver_hold = 1'b0;

		// Random blocks, each with its own rate and idling mix.
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 7))
				0: rate = TPS_WIDTH'($urandom_range(0, 65535));
				1: rate = TPS_WIDTH'($urandom_range(1, 100));
				default: rate = TPS_WIDTH'($urandom_range(100, 1200));
			endcase
			write_tick_rate(rate);
			sender_idles = ($urandom_range(0, 3) != 0);
			receiver_idles = ($urandom_range(0, 3) != 0);
			queue_random_block(150);
		end

		wait_idle();
		if (fail_count == 0)
			$display("[period_frequency_meter_bcd] OK");
		else
			$display("[period_frequency_meter_bcd] ERROR");
		$finish;
	end

endmodule
